### design/oass_pkg.sv
// ----------------------------------------------------------------------------
// oass_pkg: shared types for the ordered array shift store
// Action and status codes, controller states and the update command that is
// broadcast to every storage cell.
// ----------------------------------------------------------------------------
package oass_pkg;

    localparam int WORD_W = 32;

    // Requested action of one input beat
    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_POP    = 3'd2,
        ACT_READ   = 3'd3,
        ACT_WRITE  = 3'd4,
        ACT_FIND   = 3'd5,
        ACT_REMOVE = 3'd6
    } action_t;

    // Status reported with every result beat
    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_RANGE    = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_EMPTY    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_APPLY  = 2'd2
    } state_t;

    // What every cell does in the update cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [WORD_W-1:0]   word;
    } cell_upd_t;

endpackage

### design/oass_cell.sv
// ----------------------------------------------------------------------------
// oass_cell: one storage cell of the ordered store
// Holds one entry, takes its neighbor's entry on insert or delete shifts and
// flags a search hit by position or by value.
// ----------------------------------------------------------------------------
module oass_cell #(
    parameter int IDX   = 0,
    parameter int TW    = 7,
    parameter int CNT_W = 7
) (
    input  logic                              clk,
    input  oass_pkg::cell_upd_t               upd,
    input  logic [TW-1:0]                     upd_pos,
    input  logic signed [oass_pkg::WORD_W-1:0] left_entry,
    input  logic signed [oass_pkg::WORD_W-1:0] right_entry,
    input  logic                              by_value,
    input  logic [TW-1:0]                     target,
    input  logic [CNT_W-1:0]                  fill,
    output logic signed [oass_pkg::WORD_W-1:0] entry,
    output logic                              hit
);
    import oass_pkg::*;

    localparam logic [TW-1:0]    MY_POS  = TW'(IDX);
    localparam logic [CNT_W-1:0] MY_FILL = CNT_W'(IDX);

    logic signed [WORD_W-1:0] entry_reg;
    logic signed [WORD_W-1:0] entry_next;

    // shift or overwrite on the update cycle
    always_comb
    begin
        entry_next = entry_reg;
        case (upd.op)
            CELL_INSERT:
            begin
                if (MY_POS > upd_pos)
                    entry_next = left_entry;
                else if (MY_POS == upd_pos)
                    entry_next = upd.word;
            end
            CELL_DELETE:
            begin
                if (MY_POS >= upd_pos)
                    entry_next = right_entry;
            end
            CELL_WRITE:
            begin
                if (MY_POS == upd_pos)
                    entry_next = upd.word;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // search key: live entry equal to the word, or this slot selected
    always_comb
    begin
        if (by_value)
            hit = (entry_reg == upd.word) && (MY_FILL < fill);
        else
            hit = (MY_POS == target);
    end

    assign entry = entry_reg;

endmodule

### design/oass_tree.sv
// ----------------------------------------------------------------------------
// oass_tree: registered first-hit tree
// Reduces the cell hit flags to the lowest hit position and its entry, one
// register level per tree level, heap-ordered with padded leaves.
// ----------------------------------------------------------------------------
module oass_tree #(
    parameter int LEAVES = 64,
    parameter int IW     = 6
) (
    input  logic                               clk,
    input  logic                               leaf_hit [LEAVES],
    input  logic signed [oass_pkg::WORD_W-1:0] leaf_data [LEAVES],
    output logic                               root_hit,
    output logic [IW-1:0]                      root_pos,
    output logic signed [oass_pkg::WORD_W-1:0] root_data
);
    import oass_pkg::*;

    localparam int LV    = $clog2(LEAVES);
    localparam int NP    = 1 << LV;
    localparam int NODES = 2 * NP - 1;

    logic                     hit_reg  [NODES];
    logic [IW-1:0]            pos_reg  [NODES];
    logic signed [WORD_W-1:0] data_reg [NODES];

    // leaf level, padding leaves never hit
    for (genvar k = 0; k < NP; k++)
    begin : g_leaf
        if (k < LEAVES)
        begin : g_real
            always_ff @(posedge clk)
            begin
                hit_reg[NP-1+k]  <= leaf_hit[k];
                pos_reg[NP-1+k]  <= IW'(k);
                data_reg[NP-1+k] <= leaf_data[k];
            end
        end
        else
        begin : g_pad
            always_ff @(posedge clk)
            begin
                hit_reg[NP-1+k]  <= 1'b0;
                pos_reg[NP-1+k]  <= IW'(k);
                data_reg[NP-1+k] <= '0;
            end
        end
    end

    // inner nodes: left child wins on a hit
    for (genvar n = 0; n < NP - 1; n++)
    begin : g_node
        always_ff @(posedge clk)
        begin
            hit_reg[n] <= hit_reg[2*n+1] | hit_reg[2*n+2];
            if (hit_reg[2*n+1])
            begin
                pos_reg[n]  <= pos_reg[2*n+1];
                data_reg[n] <= data_reg[2*n+1];
            end
            else
            begin
                pos_reg[n]  <= pos_reg[2*n+2];
                data_reg[n] <= data_reg[2*n+2];
            end
        end
    end

    assign root_hit  = hit_reg[0];
    assign root_pos  = pos_reg[0];
    assign root_data = data_reg[0];

endmodule

### design/ordered_array_shift_store.sv
// ----------------------------------------------------------------------------
// ordered_array_shift_store: ordered store of signed words with shifting
// A beat passes the cell compares, each level of the first-hit tree and then
// the update cycle in which all cells shift at once; done is registered from
// the update cycle. The store takes no new beat while it searches (busy); a
// new beat can be accepted in the update cycle of the beat before.
// Reset clears the fill count, the controller and the strobe; entry contents
// are unknown until written. The receiver cannot stall the result beat.
// ----------------------------------------------------------------------------
module ordered_array_shift_store #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          action,
    input  logic [6:0]          index,
    input  logic signed [31:0]  value,
    output logic                done,
    output logic [2:0]          status,
    output logic signed [31:0]  data,
    output logic [5:0]          position,
    output logic [6:0]          count
);
    import oass_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int LV    = $clog2(CAPACITY);
    localparam int TW    = (CNT_W > 7) ? CNT_W : 7;
    localparam int SW    = $clog2(LV + 1);
    localparam int PXW   = (IW > 6) ? IW : 6;
    localparam int CXW   = (CNT_W > 7) ? CNT_W : 7;

    // controller
    state_t               state_reg;
    state_t               state_next;
    logic [SW-1:0]        step_reg;
    logic [SW-1:0]        step_next;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic                 accept;

    // command of the beat in flight
    action_t              action_reg;
    logic [6:0]           index_reg;
    logic signed [31:0]   value_reg;

    // result beat
    logic                 done_reg;
    logic                 done_next;
    status_t              status_reg;
    status_t              status_next;
    logic signed [31:0]   data_reg;
    logic signed [31:0]   data_next;
    logic [5:0]           position_reg;
    logic [5:0]           position_next;
    logic [6:0]           count_reg;
    logic [6:0]           count_next;

    // cell row and tree
    cell_upd_t            upd;
    logic [TW-1:0]        upd_pos;
    logic                 by_value;
    logic [TW-1:0]        target;
    logic signed [31:0]   cell_entry [CAPACITY];
    logic                 cell_hit   [CAPACITY];
    logic                 root_hit;
    logic [IW-1:0]        root_pos;
    logic signed [31:0]   root_data;

    logic [TW-1:0]        idx_ext;
    logic [TW-1:0]        fill_ext;
    logic [PXW-1:0]       pos_wide;
    logic [CXW-1:0]       fill_wide;
    logic [CXW-1:0]       fill_next_wide;

    assign accept = start && !busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(LV))
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (start)
                    state_next = S_SEARCH;
                else
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        case (state_reg)
            S_SEARCH: busy = 1'b1;
            default:  busy = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    // command capture on an accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action_t'(action);
            index_reg  <= index;
            value_reg  <= value;
        end
    end

    // search key: by value for find/remove, else by slot (last one for pop)
    assign idx_ext  = TW'(index_reg);
    assign fill_ext = TW'(fill_reg);
    assign by_value = (action_reg == ACT_FIND) || (action_reg == ACT_REMOVE);
    assign target   = (action_reg == ACT_POP) ? (fill_ext - TW'(1)) : idx_ext;

    // decision and cell update in the apply cycle
    always_comb
    begin
        upd.op        = CELL_HOLD;
        upd.word      = value_reg;
        upd_pos       = idx_ext;
        fill_next     = fill_reg;
        done_next     = 1'b0;
        status_next   = STAT_OK;
        data_next     = '0;
        pos_wide      = '0;
        if (state_reg == S_APPLY)
        begin
            done_next = 1'b1;
            case (action_reg)
                ACT_INSERT:
                begin
                    if (idx_ext > fill_ext)
                        status_next = STAT_RANGE;
                    else if (fill_reg == CNT_W'(CAPACITY))
                        status_next = STAT_FULL;
                    else
                    begin
                        upd.op    = CELL_INSERT;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                ACT_DELETE:
                begin
                    if (idx_ext >= fill_ext)
                        status_next = STAT_RANGE;
                    else
                    begin
                        upd.op    = CELL_DELETE;
                        fill_next = fill_reg - CNT_W'(1);
                    end
                end
                ACT_POP:
                begin
                    if (fill_reg == '0)
                        status_next = STAT_EMPTY;
                    else
                    begin
                        data_next = root_data;
                        upd.op    = CELL_DELETE;
                        upd_pos   = target;
                        fill_next = fill_reg - CNT_W'(1);
                    end
                end
                ACT_READ:
                begin
                    if (idx_ext >= fill_ext)
                        status_next = STAT_RANGE;
                    else
                        data_next = root_data;
                end
                ACT_WRITE:
                begin
                    if (idx_ext >= fill_ext)
                        status_next = STAT_RANGE;
                    else
                        upd.op = CELL_WRITE;
                end
                ACT_FIND, ACT_REMOVE:
                begin
                    if (!root_hit)
                        status_next = STAT_NOTFOUND;
                    else
                    begin
                        pos_wide = PXW'(root_pos);
                        if (action_reg == ACT_REMOVE)
                        begin
                            upd.op    = CELL_DELETE;
                            upd_pos   = TW'(root_pos);
                            fill_next = fill_reg - CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    assign fill_next_wide = CXW'(fill_next);
    assign fill_wide      = CXW'(fill_reg);
    assign position_next  = pos_wide[5:0];
    assign count_next     = fill_next_wide[6:0];

    // result beat register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_APPLY)
        begin
            status_reg   <= status_next;
            data_reg     <= data_next;
            position_reg <= position_next;
            count_reg    <= count_next;
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign data     = data_reg;
    assign position = position_reg;
    assign count    = count_reg;

    // cells wired to neighbors; value_reg and zero at the row ends
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [31:0] left_w;
        logic signed [31:0] right_w;
        if (g == 0)
        begin : g_first
            assign left_w = value_reg;
        end
        else
        begin : g_mid_l
            assign left_w = cell_entry[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_entry[g+1];
        end

        oass_cell #(
            .IDX   (g),
            .TW    (TW),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .upd         (upd),
            .upd_pos     (upd_pos),
            .left_entry  (left_w),
            .right_entry (right_w),
            .by_value    (by_value),
            .target      (target),
            .fill        (fill_reg),
            .entry       (cell_entry[g]),
            .hit         (cell_hit[g])
        );
    end

    oass_tree #(
        .LEAVES (CAPACITY),
        .IW     (IW)
    ) u_tree (
        .clk       (clk),
        .leaf_hit  (cell_hit),
        .leaf_data (cell_entry),
        .root_hit  (root_hit),
        .root_pos  (root_pos),
        .root_data (root_data)
    );

    // checks
    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_APPLY))
        else $error("result beat without an update cycle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (count == fill_wide[6:0]))
        else $error("reported count differs from fill count");

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##(LV + 2) done)
        else $error("result beat missing after accepted beat");

endmodule
